// ===== hw/rtl/ifs_pkg.sv =====
// Shared types, constants and arithmetic helpers of the chaos game block.
`default_nettype none
package ifs_pkg;

  localparam int MAX_RULES_DEF = 4;
  localparam int DRAW_W        = 10;
  localparam int RULE_W        = 2;
  localparam int PT_W          = 32;
  localparam int RC_W          = 3;
  localparam int WGT_W         = 32;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int Q_DEPTH       = 2;
  localparam int ACC_W         = 50;

  localparam logic [CFG_IDX_W-1:0] REG_RULE_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX0    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX3    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT01    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT23    = 4'd7;

  localparam logic signed [PT_W-1:0] PT_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [PT_W-1:0] PT_MIN  = 32'sh8000_0000;
  localparam logic signed [PT_W-1:0] ZERO_HI = 32'sd655360000;
  localparam logic signed [PT_W-1:0] ZERO_LO = -32'sd655360000;

  typedef struct packed {
    logic [RC_W-1:0]  rule_count;
    logic [WGT_W-1:0] weights;
  } sel_cfg_t;

  typedef struct packed {
    logic [RULE_W-1:0] rule;
    logic              clipped;
    logic              last;
  } job_t;

  // Adds one half of the last kept bit, floors to 16 fraction bits and saturates.
  function automatic logic signed [PT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] biased;
    logic signed [ACC_W-13:0] q;
    logic signed [PT_W-1:0] res;
    biased = acc + 50'sd2048;
    q = biased[ACC_W-1:12];
    if (q > $signed({{(ACC_W-12-PT_W){1'b0}}, PT_MAX})) begin
      res = PT_MAX;
    end else if (q < $signed({{(ACC_W-12-PT_W){1'b1}}, PT_MIN})) begin
      res = PT_MIN;
    end else begin
      res = q[PT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [PT_W-1:0] zero_far(input logic signed [PT_W-1:0] v);
    logic signed [PT_W-1:0] res;
    if (v > ZERO_HI || v < ZERO_LO) begin
      res = '0;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ifs_if.sv =====
// Channel interfaces for draws, results and register writes.
`default_nettype none
interface ifs_in_if;
  logic                       valid;
  logic                       ready;
  logic [ifs_pkg::DRAW_W-1:0] draw;
  logic                       last_draw;
  modport source (output valid, output draw, output last_draw, input ready);
  modport sink (input valid, input draw, input last_draw, output ready);
endinterface

interface ifs_out_if;
  logic                              valid;
  logic                              ready;
  logic [ifs_pkg::RULE_W-1:0]        rule_used;
  logic                              draw_clipped;
  logic signed [ifs_pkg::PT_W-1:0]   point_x;
  logic signed [ifs_pkg::PT_W-1:0]   point_y;
  logic signed [ifs_pkg::PT_W-1:0]   box_min_x;
  logic signed [ifs_pkg::PT_W-1:0]   box_max_x;
  logic signed [ifs_pkg::PT_W-1:0]   box_min_y;
  logic signed [ifs_pkg::PT_W-1:0]   box_max_y;
  logic                              run_done;
  modport source (output valid, output rule_used, output draw_clipped, output point_x,
                  output point_y, output box_min_x, output box_max_x, output box_min_y,
                  output box_max_y, output run_done, input ready);
  modport sink (input valid, input rule_used, input draw_clipped, input point_x,
                input point_y, input box_min_x, input box_max_x, input box_min_y,
                input box_max_y, input run_done, output ready);
endinterface

interface ifs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ifs_pkg::CFG_IDX_W-1:0]  index;
  logic [ifs_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ifs_regs.sv =====
// Configuration register file: rule count, weights, matrices and translations.
`default_nettype none
module ifs_regs #(
  parameter int MAX_RULES = ifs_pkg::MAX_RULES_DEF
) (
  input  wire                                       clk,
  input  wire                                       rst_n,
  ifs_cfg_if.sink                                   cfg_ch,
  output ifs_pkg::sel_cfg_t                         sel_cfg,
  output logic [MAX_RULES-1:0][ifs_pkg::CFG_DATA_W-1:0] matrix,
  output logic [1:0][ifs_pkg::CFG_DATA_W-1:0]       shift
);

  localparam int IDX_W = $clog2(MAX_RULES);

  ifs_pkg::sel_cfg_t                            sel_cfg_r;
  logic [MAX_RULES-1:0][ifs_pkg::CFG_DATA_W-1:0] matrix_r;
  logic [1:0][ifs_pkg::CFG_DATA_W-1:0]           shift_r;
  logic [ifs_pkg::CFG_IDX_W-1:0]                 mat_sel;

  assign cfg_ch.ready = 1'b1;
  assign mat_sel      = cfg_ch.index - ifs_pkg::REG_MATRIX0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_cfg_r.rule_count <= ifs_pkg::RC_W'(1);
      sel_cfg_r.weights    <= ifs_pkg::WGT_W'(1);
      matrix_r             <= '0;
      shift_r              <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index) inside
        ifs_pkg::REG_RULE_COUNT: sel_cfg_r.rule_count <= cfg_ch.data[ifs_pkg::RC_W-1:0];
        ifs_pkg::REG_WEIGHTS:    sel_cfg_r.weights <= cfg_ch.data[ifs_pkg::WGT_W-1:0];
        [ifs_pkg::REG_MATRIX0:ifs_pkg::REG_MATRIX3]: begin
          if (int'(mat_sel) < MAX_RULES) begin
            matrix_r[mat_sel[IDX_W-1:0]] <= cfg_ch.data;
          end
        end
        ifs_pkg::REG_SHIFT01:    shift_r[0] <= cfg_ch.data;
        ifs_pkg::REG_SHIFT23:    shift_r[1] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign sel_cfg = sel_cfg_r;
  assign matrix  = matrix_r;
  assign shift   = shift_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ifs_front.sv =====
// Front end: picks the rule for each draw from the cumulative weights.
`default_nettype none
module ifs_front #(
  parameter int MAX_RULES = ifs_pkg::MAX_RULES_DEF
) (
  ifs_in_if.sink            in_ch,
  input  ifs_pkg::sel_cfg_t sel_cfg,
  output logic              push_valid,
  input  logic              push_ready,
  output ifs_pkg::job_t     push_job
);

  localparam int RW    = ifs_pkg::RULE_W;
  localparam int CW    = ifs_pkg::RC_W;
  localparam int SUM_W = $clog2(MAX_RULES * 255 + 1);
  localparam int CMP_W = ((SUM_W > ifs_pkg::DRAW_W) ? SUM_W : ifs_pkg::DRAW_W) + 1;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    logic [CW-1:0]    active;
    logic [CMP_W-1:0] sum;
    logic [CMP_W-1:0] draw_ext;
    logic             found;
    logic [RW-1:0]    rule;
    active = sel_cfg.rule_count;
    if (active == '0) begin
      active = CW'(1);
    end else if (active > CW'(MAX_RULES)) begin
      active = CW'(MAX_RULES);
    end
    draw_ext = {{(CMP_W - ifs_pkg::DRAW_W){1'b0}}, in_ch.draw};
    rule     = RW'(active - CW'(1));
    sum      = '0;
    found    = 1'b0;
    for (int i = 0; i < MAX_RULES; i++) begin
      if (CW'(i) < active) begin
        sum = sum + {{(CMP_W - 8){1'b0}}, sel_cfg.weights[8*i +: 8]};
        if (!found && draw_ext < sum) begin
          rule  = RW'(i);
          found = 1'b1;
        end
      end
    end
    push_job.rule    = rule;
    push_job.clipped = !found;
    push_job.last    = in_ch.last_draw;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ifs_queue.sv =====
// Short queue of classified draws between the front and back ends.
`default_nettype none
module ifs_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  ifs_pkg::job_t        push_job,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output ifs_pkg::job_t        pop_job
);

  localparam int DEPTH = ifs_pkg::Q_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  ifs_pkg::job_t    entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             push;
  logic             pop;

  assign push_ready = count_r != (PTR_W + 1)'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (PTR_W + 1)'(1);
        2'b01:   count_r <= count_r - (PTR_W + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ifs_back.sv =====
// Back end: affine update of the kept point, then zeroing of far coordinates, bounding box and output register.
`default_nettype none
module ifs_back #(
  parameter int MAX_RULES = ifs_pkg::MAX_RULES_DEF
) (
  input  wire                                           clk,
  input  wire                                           rst_n,
  input  logic                                          job_valid,
  output logic                                          job_ready,
  input  ifs_pkg::job_t                                 job,
  input  logic [MAX_RULES-1:0][ifs_pkg::CFG_DATA_W-1:0] matrix,
  input  logic [1:0][ifs_pkg::CFG_DATA_W-1:0]           shift,
  ifs_out_if.source                                     out_ch
);

  localparam int IDX_W = $clog2(MAX_RULES);
  localparam int PW    = ifs_pkg::PT_W;
  localparam int AW    = ifs_pkg::ACC_W;

  logic signed [PW-1:0] cur_x_r, cur_y_r, cur_x_nxt, cur_y_nxt;
  logic signed [PW-1:0] low_x_r, high_x_r, low_y_r, high_y_r;
  logic signed [PW-1:0] low_x_nxt, high_x_nxt, low_y_nxt, high_y_nxt;
  logic signed [PW-1:0] s1_x_r, s1_y_r;
  ifs_pkg::job_t        s1_job_r;
  logic                 s1_valid_r;
  logic                 out_valid_r;
  logic                 job_take, s1_adv, out_free;

  logic [ifs_pkg::CFG_DATA_W-1:0] mat, sh;
  logic signed [15:0]   a, b, c, d, tx, ty;
  logic signed [47:0]   pax, pby, pcx, pdy;
  logic signed [AW-1:0] acc_x, acc_y;
  logic signed [PW-1:0] px, py;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign job_ready = !s1_valid_r || s1_adv;
  assign job_take  = job_valid && job_ready;

  assign mat = matrix[job.rule[IDX_W-1:0]];
  assign sh  = shift[job.rule[1]];
  assign a   = $signed(mat[15:0]);
  assign b   = $signed(mat[31:16]);
  assign c   = $signed(mat[47:32]);
  assign d   = $signed(mat[63:48]);
  assign tx  = job.rule[0] ? $signed(sh[47:32]) : $signed(sh[15:0]);
  assign ty  = job.rule[0] ? $signed(sh[63:48]) : $signed(sh[31:16]);

  assign pax = a * cur_x_r;
  assign pby = b * cur_y_r;
  assign pcx = c * cur_x_r;
  assign pdy = d * cur_y_r;

  assign acc_x = $signed({{2{pax[47]}}, pax}) + $signed({{2{pby[47]}}, pby})
               + $signed({{(AW-32){tx[15]}}, tx, 16'b0});
  assign acc_y = $signed({{2{pcx[47]}}, pcx}) + $signed({{2{pdy[47]}}, pdy})
               + $signed({{(AW-32){ty[15]}}, ty, 16'b0});

  assign cur_x_nxt = ifs_pkg::round_sat(acc_x);
  assign cur_y_nxt = ifs_pkg::round_sat(acc_y);

  assign px = ifs_pkg::zero_far(s1_x_r);
  assign py = ifs_pkg::zero_far(s1_y_r);

  assign low_x_nxt  = (px < low_x_r)  ? px : low_x_r;
  assign high_x_nxt = (px > high_x_r) ? px : high_x_r;
  assign low_y_nxt  = (py < low_y_r)  ? py : low_y_r;
  assign high_y_nxt = (py > high_y_r) ? py : high_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      low_x_r     <= ifs_pkg::PT_MAX;
      low_y_r     <= ifs_pkg::PT_MAX;
      high_x_r    <= ifs_pkg::PT_MIN;
      high_y_r    <= ifs_pkg::PT_MIN;
    end else begin
      if (job_take) begin
        cur_x_r <= job.last ? '0 : cur_x_nxt;
        cur_y_r <= job.last ? '0 : cur_y_nxt;
      end
      if (s1_adv) begin
        low_x_r  <= s1_job_r.last ? ifs_pkg::PT_MAX : low_x_nxt;
        low_y_r  <= s1_job_r.last ? ifs_pkg::PT_MAX : low_y_nxt;
        high_x_r <= s1_job_r.last ? ifs_pkg::PT_MIN : high_x_nxt;
        high_y_r <= s1_job_r.last ? ifs_pkg::PT_MIN : high_y_nxt;
      end
      s1_valid_r  <= job_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
      out_valid_r <= s1_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      s1_job_r <= job;
      s1_x_r   <= cur_x_nxt;
      s1_y_r   <= cur_y_nxt;
    end
    if (s1_adv) begin
      out_ch.rule_used    <= s1_job_r.rule;
      out_ch.draw_clipped <= s1_job_r.clipped;
      out_ch.run_done     <= s1_job_r.last;
      out_ch.point_x      <= px;
      out_ch.point_y      <= py;
      out_ch.box_min_x    <= low_x_nxt;
      out_ch.box_max_x    <= high_x_nxt;
      out_ch.box_min_y    <= low_y_nxt;
      out_ch.box_max_y    <= high_y_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ifs_chaos_game_2d.sv =====
// Top level of the two-dimensional chaos game block.
// The block sustains one draw per clock cycle when the result side does not stall and
// returns one result for each draw, in order, through the queue, the stage-one register
// and the output register. The rate is set by the combinational update of the kept point
// (four 16x32 multiplies, the sums, rounding and saturation feed back into the point
// registers) and by the combinational bounding box compare. A two-entry queue sits between
// rule selection and the point update, and a registered output stage lets a new draw be
// taken while a finished result waits. The user must write registers only while no draw
// is in flight; the block does not enforce this. There is no clearing pass after reset.
`default_nettype none
module ifs_chaos_game_2d #(
  parameter int MAX_RULES = ifs_pkg::MAX_RULES_DEF
) (
  input wire         clk,
  input wire         rst_n,
  ifs_in_if.sink     in_ch,
  ifs_out_if.source  out_ch,
  ifs_cfg_if.sink    cfg_ch
);

  ifs_pkg::sel_cfg_t                             sel_cfg;
  logic [MAX_RULES-1:0][ifs_pkg::CFG_DATA_W-1:0] matrix;
  logic [1:0][ifs_pkg::CFG_DATA_W-1:0]           shift;
  logic                                          push_valid, push_ready;
  logic                                          pop_valid, pop_ready;
  ifs_pkg::job_t                                 push_job, pop_job;

  ifs_regs #(.MAX_RULES(MAX_RULES)) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .sel_cfg (sel_cfg),
    .matrix  (matrix),
    .shift   (shift)
  );

  ifs_front #(.MAX_RULES(MAX_RULES)) u_front (
    .in_ch      (in_ch),
    .sel_cfg    (sel_cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  ifs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  ifs_back #(.MAX_RULES(MAX_RULES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .matrix    (matrix),
    .shift     (shift),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/ifs_chk.sv =====
// Port-level assertions for the chaos game block and the bind that attaches them.
`default_nettype none
module ifs_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire signed [ifs_pkg::PT_W-1:0]   point_x,
  input wire signed [ifs_pkg::PT_W-1:0]   point_y,
  input wire signed [ifs_pkg::PT_W-1:0]   box_min_x,
  input wire signed [ifs_pkg::PT_W-1:0]   box_max_x,
  input wire signed [ifs_pkg::PT_W-1:0]   box_min_y,
  input wire signed [ifs_pkg::PT_W-1:0]   box_max_y
);

  // A result on the port always lies inside the box reported with it.
  a_box_holds_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (box_min_x <= point_x) && (point_x <= box_max_x) &&
                  (box_min_y <= point_y) && (point_y <= box_max_y))
    else $error("result point lies outside its bounding box");

  // Far coordinates are zeroed, so every shown point stays within the limit.
  a_point_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (point_x <= ifs_pkg::ZERO_HI) && (point_x >= ifs_pkg::ZERO_LO) &&
                  (point_y <= ifs_pkg::ZERO_HI) && (point_y >= ifs_pkg::ZERO_LO))
    else $error("result point beyond the zeroing limit");

  // No result may appear in the cycle after reset.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled transfer keeps its point, its minimum x and its maximum y.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y) &&
                                $stable(box_min_x) && $stable(box_max_y))
    else $error("stalled result changed");

endmodule

bind ifs_chaos_game_2d ifs_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .point_x   (out_ch.point_x),
  .point_y   (out_ch.point_y),
  .box_min_x (out_ch.box_min_x),
  .box_max_x (out_ch.box_max_x),
  .box_min_y (out_ch.box_min_y),
  .box_max_y (out_ch.box_max_y)
);
`default_nettype wire
